@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/rbpf_pkg.sv @@
// ---------------------------------------------------------------------------
// rbpf_pkg
// Widths, types and field helpers for the rotated box point filter.
// ---------------------------------------------------------------------------
package rbpf_pkg;

    localparam int COORD_W   = 20;
    localparam int COEF_W    = 18;
    localparam int FRAC_BITS = COEF_W - 2;

    localparam int NUM_REGS  = 7;
    localparam int CFG_IDX_W = $clog2(NUM_REGS + 1);
    localparam int ROW_W     = 3 * COEF_W;
    localparam int XYZ_W     = 3 * COORD_W;
    localparam int CFG_DATA_W = (ROW_W > XYZ_W) ? ROW_W : XYZ_W;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = COEF_W + DIFF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int ROT_W  = ACC_W - FRAC_BITS;
    localparam int BND_W  = COORD_W + 2;
    localparam int RES_W  = ((ROT_W > BND_W) ? ROT_W : BND_W) + 1;

    localparam int IN_TDATA_W  = ((XYZ_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_X  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_Y  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_Z  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_XYZ  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BOX_LOW    = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_BOX_HIGH   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_XYZ = CFG_IDX_W'(6);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [BND_W-1:0]   bound_t;

    // Decoded configuration; the user must keep it held steady while items are in flight (not enforced here).
    typedef struct packed {
        coef_t  [2:0][2:0] coef;
        coord_t [2:0]      pivot;
        bound_t [2:0]      lo;
        bound_t [2:0]      hi;
    } cfg_t;

    // One rotated-sum beat between the rotation pipe and the box check.
    typedef struct packed {
        logic         valid;
        acc_t [2:0]   acc;
    } acc_beat_t;

    function automatic coef_t coef_field(input logic [ROW_W-1:0] row, input int idx);
        coef_field = coef_t'(row[idx*COEF_W +: COEF_W]);
    endfunction

    function automatic coord_t coord_field(input logic [XYZ_W-1:0] v, input int idx);
        coord_field = coord_t'(v[idx*COORD_W +: COORD_W]);
    endfunction

endpackage

@@ rtl/rbpf_cfg.sv @@
// ---------------------------------------------------------------------------
// rbpf_cfg
// Configuration registers with decoded coefficients, pivot and widened box.
// ---------------------------------------------------------------------------
module rbpf_cfg
    import rbpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [ROW_W-1:0] rot_row_x_reg, rot_row_y_reg, rot_row_z_reg;
    logic [XYZ_W-1:0] pivot_xyz_reg, box_low_reg, box_high_reg, margin_xyz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row_x_reg  <= ROW_W'(1) << FRAC_BITS;
            rot_row_y_reg  <= ROW_W'(1) << (FRAC_BITS + COEF_W);
            rot_row_z_reg  <= ROW_W'(1) << (FRAC_BITS + 2 * COEF_W);
            pivot_xyz_reg  <= '0;
            box_low_reg    <= '0;
            box_high_reg   <= '0;
            margin_xyz_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROT_ROW_X:  rot_row_x_reg  <= cfg_data[ROW_W-1:0];
                REG_ROT_ROW_Y:  rot_row_y_reg  <= cfg_data[ROW_W-1:0];
                REG_ROT_ROW_Z:  rot_row_z_reg  <= cfg_data[ROW_W-1:0];
                REG_PIVOT_XYZ:  pivot_xyz_reg  <= cfg_data[XYZ_W-1:0];
                REG_BOX_LOW:    box_low_reg    <= cfg_data[XYZ_W-1:0];
                REG_BOX_HIGH:   box_high_reg   <= cfg_data[XYZ_W-1:0];
                REG_MARGIN_XYZ: margin_xyz_reg <= cfg_data[XYZ_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        logic [COORD_W-1:0] m;
        coord_t             bl;
        coord_t             bh;
        for (int j = 0; j < 3; j++)
        begin
            cfg.coef[0][j] = coef_field(rot_row_x_reg, j);
            cfg.coef[1][j] = coef_field(rot_row_y_reg, j);
            cfg.coef[2][j] = coef_field(rot_row_z_reg, j);
        end
        for (int i = 0; i < 3; i++)
        begin
            m  = margin_xyz_reg[i*COORD_W +: COORD_W];
            bl = coord_field(box_low_reg, i);
            bh = coord_field(box_high_reg, i);
            cfg.pivot[i] = coord_field(pivot_xyz_reg, i);
            // The margin is unsigned, so it widens with zeros.
            cfg.lo[i] = bound_t'({{2{bl[COORD_W-1]}}, bl}) - bound_t'({2'b00, m});
            cfg.hi[i] = bound_t'({{2{bh[COORD_W-1]}}, bh}) + bound_t'({2'b00, m});
        end
    end

endmodule

@@ rtl/rbpf_rot.sv @@
// ---------------------------------------------------------------------------
// rbpf_rot
// Pivot subtraction, nine coefficient products and per-row sums, one stage each.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbpf_rot
    import rbpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  coord_t [2:0] in_point,
    output acc_beat_t   out_beat,
    input  logic        out_ready
);

    logic va_reg, vb_reg, vc_reg;
    diff_t [2:0]      d_reg, d_next;
    prod_t [2:0][2:0] p_reg, p_next;
    acc_t  [2:0]      acc_reg, acc_next;
    logic ready_a, ready_b, ready_c;

    assign ready_c  = !vc_reg || out_ready;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            d_next[j] = diff_t'({in_point[j][COORD_W-1], in_point[j]})
                      - diff_t'({cfg.pivot[j][COORD_W-1], cfg.pivot[j]});
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_next[i][j] = prod_t'(cfg.coef[i][j]) * prod_t'(d_reg[j]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = acc_t'(p_reg[i][0]) + acc_t'(p_reg[i][1]) + acc_t'(p_reg[i][2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
            if (ready_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            d_reg <= d_next;
        end
        if (ready_b && va_reg)
        begin
            p_reg <= p_next;
        end
        if (ready_c && vb_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign out_beat.valid = vc_reg;
    assign out_beat.acc   = acc_reg;

    // Input back-pressure only arises when every stage is full and the output stalls.
    `ASSERT_CLK(a_full_when_blocked,
        !in_ready |-> (va_reg && vb_reg && vc_reg && !out_ready),
        "rotation pipe blocked input with a free stage")
    // A stalled sum beat keeps its value.
    `ASSERT_CLK(a_sum_held,
        (vc_reg && !out_ready) |=> (vc_reg && $stable(acc_reg)),
        "sum beat changed while stalled")
    // A product beat moves on as soon as the sum stage has room.
    `ASSERT_CLK(a_prod_advances,
        (vb_reg && ready_c) |=> vc_reg,
        "product beat lost on its way to the sum stage")

endmodule

@@ rtl/rbpf_chk.sv @@
// ---------------------------------------------------------------------------
// rbpf_chk
// Floor shift, pivot re-add and inclusive box test into the result register.
// ---------------------------------------------------------------------------
module rbpf_chk
    import rbpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  acc_beat_t in_beat,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      out_hit
);

    logic valid_reg;
    logic hit_reg, hit_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        acc_t                shifted;
        logic [ROT_W-1:0]    rot;
        logic signed [RES_W-1:0] r;
        logic signed [RES_W-1:0] lo;
        logic signed [RES_W-1:0] hi;
        hit_next = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            // Arithmetic shift floors towards minus infinity.
            shifted = in_beat.acc[i] >>> FRAC_BITS;
            rot     = shifted[ROT_W-1:0];
            r  = $signed({{(RES_W-ROT_W){rot[ROT_W-1]}}, rot})
               + $signed({{(RES_W-COORD_W){cfg.pivot[i][COORD_W-1]}}, cfg.pivot[i]});
            lo = $signed({{(RES_W-BND_W){cfg.lo[i][BND_W-1]}}, cfg.lo[i]});
            hi = $signed({{(RES_W-BND_W){cfg.hi[i][BND_W-1]}}, cfg.hi[i]});
            if (r < lo || r > hi)
            begin
                hit_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_beat.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_beat.valid)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_hit   = hit_reg;

endmodule

@@ rtl/rotated_box_point_filter_top.sv @@
// ---------------------------------------------------------------------------
// rotated_box_point_filter_top
// Rotates each point about the pivot and flags it when inside the widened box.
// ---------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_*      in         point_x, point_y, point_z (signed, 20 bits each)
//  m_*      out        self_hit (1 bit)
//  cfg_*    in         seven configuration registers, write only
//
//  One point is taken in every clock cycle while s_tready is high; each beat yields
//  exactly one result, through four register stages (pivot subtract, products, row
//  sums, box test), the first loaded on accept.
//  rst_n clears all stage valid flags and loads the identity rotation at once.
//  A stall on m_tready fills the four stages before s_tready drops.
// ---------------------------------------------------------------------------
module rotated_box_point_filter_top
    import rbpf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // point_x, point_y, point_z, zero fill
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // self_hit, zero fill
);

    cfg_t         cfg;
    coord_t [2:0] point;
    acc_beat_t    sum_beat;
    logic         sum_ready;
    logic         hit;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            point[j] = coord_t'(s_tdata[j*COORD_W +: COORD_W]);
        end
    end

    rbpf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbpf_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_point  (point),
        .out_beat  (sum_beat),
        .out_ready (sum_ready)
    );

    rbpf_chk u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_beat   (sum_beat),
        .in_ready  (sum_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (hit)
    );

    assign m_tdata = {{(OUT_TDATA_W-1){1'b0}}, hit};

endmodule
